// File: hw/rtl/elr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// elr_pkg: shared types and constants of the eased level ramp
// Holds the operation, register and curve codes, the controller state type,
// the control and status bundles, and the exponent table built at elaboration.
// ----------------------------------------------------------------------------
package elr_pkg;

  localparam int LEVEL_W    = 16;
  localparam int FRAC_W     = 16;
  localparam int EXP_BITS   = 8;
  localparam int EXP_SIZE   = 1 << EXP_BITS;
  localparam int ROM_W      = 31;
  localparam int DUR_W      = 16;
  localparam int MODE_W     = 2;
  localparam int CNT_W      = 4;
  localparam int DUR_RESET  = 1000;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } elr_op_e;

  typedef enum logic [1:0] {
    REG_START_LEVEL = 2'd0,
    REG_END_LEVEL   = 2'd1,
    REG_DURATION    = 2'd2,
    REG_CURVE_MODE  = 2'd3
  } elr_reg_e;

  typedef enum logic [1:0] {
    CURVE_LINEAR = 2'd0,
    CURVE_EXP    = 2'd1,
    CURVE_QUAD   = 2'd2
  } elr_curve_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FRAC,
    ST_SQUARE,
    ST_SHAPE,
    ST_SCALE,
    ST_LEVEL,
    ST_EMIT
  } elr_state_e;

  typedef enum logic {
    MUL_SQUARE = 1'b0,
    MUL_SCALE  = 1'b1
  } elr_mul_e;

  typedef struct packed {
    logic     start;
    logic     tick;
    logic     div_step;
    logic     frac;
    logic     mul;
    elr_mul_e mul_sel;
    logic     shape;
    logic     level;
    logic     emit;
  } elr_cmd_t;

  typedef struct packed {
    logic imm_end;
    logic div_last;
    logic emit_needed;
    logic done;
  } elr_status_t;

  typedef logic [ROM_W-1:0] exp_rom_t [EXP_SIZE];

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bval;
    v    = val;
    res  = 64'd0;
    bval = 64'd1 << 62;
    while (bval > v) begin
      bval = bval >> 2;
    end
    while (bval != 64'd0) begin
      if (v >= res + bval) begin
        v   = v - (res + bval);
        res = (res >> 1) + bval;
      end else begin
        res = res >> 1;
      end
      bval = bval >> 2;
    end
    return res;
  endfunction

  function automatic exp_rom_t exp_rom_build();
    logic [63:0] s [EXP_BITS+1];
    logic [63:0] acc;
    exp_rom_t    rom;
    s[EXP_BITS] = 64'd1 << 29;
    for (int b = EXP_BITS - 1; b >= 0; b--) begin
      s[b] = isqrt64(s[b+1] << 30);
    end
    for (int k = 0; k < EXP_SIZE; k++) begin
      acc = 64'd1 << 30;
      for (int b = 0; b < EXP_BITS; b++) begin
        if (((k >> b) & 1) != 0) begin
          acc = (acc * s[b]) >> 30;
        end
      end
      rom[k] = acc[ROM_W-1:0];
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = exp_rom_build();

endpackage
`default_nettype wire

// File: hw/rtl/eased_level_ramp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eased_level_ramp: eased ramp from a start level to an end level
// A start transaction latches start level, end level, duration and curve and
// arms the ramp; if the levels are equal or the duration is zero it instead
// returns the end level, marked finished.
// Each tick on an armed ramp advances progress by one tick up to the duration,
// divides it by the duration with a bit-serial divider (16 steps), shapes the
// fraction with the selected curve, scales the level span on a shared
// multiplier and returns a result when the level moved or the ramp ended.
// A tick passes from acceptance through the 16 divider steps and the fraction,
// square, shape, scale and level steps to the result register; one
// transaction is worked on at a time, so the input is ready again only in idle.
// The result sits in an output register, so the next transaction is taken
// while an earlier result waits; a stalled receiver holds the block only
// when the following transaction reaches its emit step.
// Configuration writes apply at the next start.
// Reset returns the block to idle with the ramp disarmed, the current level
// at zero and the configuration registers at their defaults.
// ----------------------------------------------------------------------------
module eased_level_ramp
  import elr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [DUR_W-1:0]   cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               operation_i,
  input  wire logic               stop_request_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [LEVEL_W-1:0]      level_o,
  output logic                    level_changed_o,
  output logic                    finished_o
);

  elr_cmd_t    cmd;
  elr_status_t status;

  elr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  elr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .stop_request_i  (stop_request_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .level_o         (level_o),
    .level_changed_o (level_changed_o),
    .finished_o      (finished_o)
  );

endmodule
`default_nettype wire

// File: hw/rtl/elr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// elr_ctrl: sequencer of the eased level ramp
// Accepts transactions, steps the datapath through division, shaping and
// interpolation, and owns the ramp activity flag and the output valid.
// ----------------------------------------------------------------------------
module elr_ctrl
  import elr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        operation_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  input  wire elr_status_t status_i,
  output elr_cmd_t         cmd_o
);

  elr_state_e state_q, state_d;
  logic       active_q, active_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire;
  logic       out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (operation_i == OP_START) begin
            if (status_i.imm_end) begin
              state_d = ST_EMIT;
            end
          end else if (active_q) begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (status_i.div_last) begin
          state_d = ST_FRAC;
        end
      end
      ST_FRAC:   state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_SHAPE;
      ST_SHAPE:  state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_LEVEL;
      ST_LEVEL:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.mul_sel = MUL_SQUARE;
    active_d    = active_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (operation_i == OP_START) begin
            cmd_o.start = 1'b1;
            active_d    = !status_i.imm_end;
          end else if (active_q) begin
            cmd_o.tick = 1'b1;
          end
        end
      end
      ST_DIV:    cmd_o.div_step = 1'b1;
      ST_FRAC:   cmd_o.frac = 1'b1;
      ST_SQUARE: begin
        cmd_o.mul     = 1'b1;
        cmd_o.mul_sel = MUL_SQUARE;
      end
      ST_SHAPE:  cmd_o.shape = 1'b1;
      ST_SCALE: begin
        cmd_o.mul     = 1'b1;
        cmd_o.mul_sel = MUL_SCALE;
      end
      ST_LEVEL:  cmd_o.level = 1'b1;
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.emit_needed) begin
            out_valid_d = 1'b1;
          end
          if (status_i.done) begin
            active_d = 1'b0;
          end
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/elr_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// elr_datapath: arithmetic of the eased level ramp
// Holds the configuration and ramp state, a bit-serial divider for the
// fraction, one shared multiplier, the curve shaping and the output register.
// ----------------------------------------------------------------------------
module elr_datapath
  import elr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [DUR_W-1:0]    cfg_data_i,
  input  wire logic                stop_request_i,
  input  wire elr_cmd_t            cmd_i,
  output elr_status_t              status_o,
  output logic [LEVEL_W-1:0]       level_o,
  output logic                     level_changed_o,
  output logic                     finished_o
);

  localparam logic [FRAC_W:0] ONE = (FRAC_W+1)'(1) << FRAC_W;

  logic [LEVEL_W-1:0] cfg_start_q, cfg_end_q;
  logic [DUR_W-1:0]   cfg_dur_q;
  logic [MODE_W-1:0]  cfg_mode_q;

  logic [LEVEL_W-1:0] lat_start_q, lat_end_q;
  logic [DUR_W-1:0]   lat_dur_q;
  logic [MODE_W-1:0]  lat_mode_q;

  logic [DUR_W-1:0]   elapsed_q, elapsed_d;
  logic [LEVEL_W-1:0] cur_level_q;
  logic               stop_q;

  logic [DUR_W-1:0]   rem_q;
  logic [FRAC_W-1:0]  quo_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DUR_W:0]     rem_shift;
  logic               rem_ge;

  logic [FRAC_W:0]    f_d, f_q;
  logic [FRAC_W+3:0]  x_mul;
  logic [EXP_BITS-1:0] exp_idx_q;
  logic [3:0]         exp_sh_q;

  logic [FRAC_W:0]    sq_base;
  logic [FRAC_W:0]    mul_a, mul_b;
  logic [2*FRAC_W+1:0] prod_q;

  logic [FRAC_W:0]    g_d, g_q;
  logic [ROM_W-1:0]   rom_val;
  logic [ROM_W-1:0]   rom_shift;

  logic               up;
  logic [LEVEL_W-1:0] diff;
  logic [2*FRAC_W+1:0] prod_round;
  logic [LEVEL_W-1:0] lvl_d;
  logic [LEVEL_W-1:0] res_level_q;
  logic               res_done_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_start_q <= '0;
      cfg_end_q   <= '0;
      cfg_dur_q   <= DUR_W'(DUR_RESET);
      cfg_mode_q  <= CURVE_LINEAR;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_START_LEVEL: cfg_start_q <= cfg_data_i[LEVEL_W-1:0];
        REG_END_LEVEL:   cfg_end_q   <= cfg_data_i[LEVEL_W-1:0];
        REG_DURATION:    cfg_dur_q   <= cfg_data_i;
        REG_CURVE_MODE:  cfg_mode_q  <= cfg_data_i[MODE_W-1:0];
        default:         cfg_mode_q  <= cfg_mode_q;
      endcase
    end
  end

  assign elapsed_d = (elapsed_q < lat_dur_q) ? elapsed_q + DUR_W'(1) : elapsed_q;

  // Ramp state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q   <= '0;
      cur_level_q <= '0;
    end else begin
      if (cmd_i.start) begin
        elapsed_q <= '0;
        if (!status_o.imm_end) begin
          cur_level_q <= cfg_start_q;
        end
      end else if (cmd_i.tick) begin
        elapsed_q <= elapsed_d;
      end
      if (cmd_i.emit && status_o.emit_needed) begin
        cur_level_q <= res_level_q;
      end
    end
  end

  // Divider: one quotient bit per step; the remainder stays below the duration while progress is below it.
  assign rem_shift = {rem_q, 1'b0};
  assign rem_ge    = (rem_shift >= {1'b0, lat_dur_q});

  always_comb begin
    if (elapsed_q == lat_dur_q) begin
      f_d = ONE;
    end else begin
      f_d = {1'b0, quo_q};
    end
  end

  assign x_mul = ((FRAC_W+4)'(f_d[FRAC_W-1:0]) << 3) + ((FRAC_W+4)'(f_d[FRAC_W-1:0]) << 1);

  always_comb begin
    if (f_q < (ONE >> 1)) begin
      sq_base = f_q;
    end else begin
      sq_base = ONE - f_q;
    end
  end

  assign up   = (lat_end_q >= lat_start_q);
  assign diff = up ? (lat_end_q - lat_start_q) : (lat_start_q - lat_end_q);

  always_comb begin
    if (cmd_i.mul_sel == MUL_SCALE) begin
      mul_a = {1'b0, diff};
      mul_b = g_q;
    end else begin
      mul_a = sq_base;
      mul_b = sq_base;
    end
  end

  assign rom_val   = EXP_ROM[exp_idx_q];
  assign rom_shift = (rom_val >> (FRAC_W - 2)) >> exp_sh_q;

  always_comb begin
    case (lat_mode_q)
      CURVE_QUAD: begin
        if (f_q < (ONE >> 1)) begin
          g_d = prod_q[FRAC_W+15:FRAC_W-1];
        end else begin
          g_d = ONE - prod_q[FRAC_W+15:FRAC_W-1];
        end
      end
      CURVE_EXP: begin
        if (f_q == ONE) begin
          g_d = ONE;
        end else begin
          g_d = ONE - rom_shift[FRAC_W:0];
        end
      end
      default: g_d = f_q;
    endcase
  end

  assign prod_round = prod_q + (2*FRAC_W+2)'(ONE - 1'b1);

  always_comb begin
    if (up) begin
      lvl_d = lat_start_q + prod_q[FRAC_W+LEVEL_W-1:FRAC_W];
    end else begin
      lvl_d = lat_start_q - prod_round[FRAC_W+LEVEL_W-1:FRAC_W];
    end
  end

  // Working registers of one transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      lat_start_q <= cfg_start_q;
      lat_end_q   <= cfg_end_q;
      lat_dur_q   <= cfg_dur_q;
      lat_mode_q  <= cfg_mode_q;
      res_level_q <= cfg_end_q;
      res_done_q  <= 1'b1;
    end
    if (cmd_i.tick) begin
      stop_q <= stop_request_i;
      rem_q  <= elapsed_d;
      quo_q  <= '0;
      cnt_q  <= '0;
    end
    if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_q <= DUR_W'(rem_shift - {1'b0, lat_dur_q});
      end else begin
        rem_q <= rem_shift[DUR_W-1:0];
      end
      quo_q <= {quo_q[FRAC_W-2:0], rem_ge};
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.frac) begin
      f_q       <= f_d;
      exp_idx_q <= x_mul[FRAC_W-1:FRAC_W-EXP_BITS];
      exp_sh_q  <= x_mul[FRAC_W+3:FRAC_W];
    end
    if (cmd_i.mul) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.shape) begin
      g_q <= g_d;
    end
    if (cmd_i.level) begin
      res_level_q <= lvl_d;
      res_done_q  <= stop_q || (elapsed_q >= lat_dur_q);
    end
    if (cmd_i.emit && status_o.emit_needed) begin
      level_o         <= res_level_q;
      level_changed_o <= (res_level_q != cur_level_q);
      finished_o      <= res_done_q;
    end
  end

  assign status_o.imm_end     = (cfg_start_q == cfg_end_q) || (cfg_dur_q == '0);
  assign status_o.div_last    = (cnt_q == CNT_W'(FRAC_W - 1));
  assign status_o.emit_needed = (res_level_q != cur_level_q) || res_done_q;
  assign status_o.done        = res_done_q;

endmodule
`default_nettype wire
